// ----- rtl/core/multibrot_escape_iteration_unit_macros.svh -----
// Assertion macros shared by the multibrot escape iteration unit
`ifndef MULTIBROT_ESCAPE_ITERATION_UNIT_MACROS_SVH
`define MULTIBROT_ESCAPE_ITERATION_UNIT_MACROS_SVH

// cons must hold whenever ante holds
`define MEI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define MEI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/mei_pkg.sv -----
// Shared types and constants of the multibrot escape iteration unit
package mei_pkg;

    localparam int DATA_BITS  = 64;                 // even
    localparam int FRAC_BITS  = 60;
    localparam int COUNT_BITS = 20;

    localparam int HALF_BITS  = DATA_BITS / 2;
    localparam int PROD_BITS  = 2 * DATA_BITS;
    localparam int PP_BITS    = 2 * HALF_BITS + 2;
    localparam int SQ_BITS    = PROD_BITS - FRAC_BITS;
    localparam int BAIL_BITS  = 63;
    localparam int MAG_BITS   = (SQ_BITS + 1 > BAIL_BITS) ? SQ_BITS + 1 : BAIL_BITS;
    localparam int POW_BITS   = 5;
    localparam int POW_MIN    = 2;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [COUNT_BITS-1:0] MAX_COUNT_RESET = COUNT_BITS'(256);
    localparam logic [BAIL_BITS-1:0]  BAIL_RESET      = BAIL_BITS'(1) << (FRAC_BITS + 2);
    localparam logic [POW_BITS-1:0]   POW_RESET       = POW_BITS'(POW_MIN);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MAX_COUNT = 2'd0,
        CFG_BAILOUT   = 2'd1,
        CFG_POWER     = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OPD_ZR = 2'd0,
        OPD_ZI = 2'd1,
        OPD_RE = 2'd2,
        OPD_IM = 2'd3
    } opd_sel_t;

    typedef enum logic [2:0] {
        DST_NONE  = 3'd0,
        DST_SX    = 3'd1,
        DST_SY    = 3'd2,
        DST_CROSS = 3'd3,
        DST_T0    = 3'd4,
        DST_T1    = 3'd5,
        DST_RE    = 3'd6,
        DST_IM    = 3'd7
    } mul_dst_t;

    typedef struct packed {
        logic     load;
        logic     mul_start;
        opd_sel_t a_sel;
        opd_sel_t b_sel;
        mul_dst_t dst;
        logic     pw_init;
        logic     pw_step;
        logic     update;
        logic     publish;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic mag_over;
        logic count_below;
        logic pw_more;
    } dp_sts_t;

endpackage

// ----- rtl/core/multibrot_escape_iteration_unit.sv -----
// Top level of the multibrot escape iteration unit
//
//  channel   direction  request payload
//  s_        in         c_real, c_imag, z_real, z_imag, start_count
//  m_        out        final_count, final_real, final_imag, escaped
//  cfg_      in         cfg_index (0 max_count, 1 bailout, 2 power), cfg_data
//
// Every product runs on the shared 4-step multiplier; an iteration takes
// three products plus four per power above 2, and each request adds load and finish.
// One request is worked on at a time; the next is taken once the result sits
// in the output register. Reset returns control and config registers to their defaults.
// A stalled m_ready holds the result and, for a second one, the core.
module multibrot_escape_iteration_unit (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [mei_pkg::DATA_BITS-1:0]     s_c_real,
    input  logic signed [mei_pkg::DATA_BITS-1:0]     s_c_imag,
    input  logic signed [mei_pkg::DATA_BITS-1:0]     s_z_real,
    input  logic signed [mei_pkg::DATA_BITS-1:0]     s_z_imag,
    input  logic [mei_pkg::COUNT_BITS-1:0]           s_start_count,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [mei_pkg::COUNT_BITS-1:0]           m_final_count,
    output logic signed [mei_pkg::DATA_BITS-1:0]     m_final_real,
    output logic signed [mei_pkg::DATA_BITS-1:0]     m_final_imag,
    output logic                                     m_escaped,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [mei_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [mei_pkg::CFG_DATA_BITS-1:0]        cfg_data
);

    mei_pkg::dp_cmd_t cmd;
    mei_pkg::dp_sts_t sts;

    assign cfg_ready = 1'b1;

    mei_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    mei_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_c_real       (s_c_real),
        .in_c_imag       (s_c_imag),
        .in_z_real       (s_z_real),
        .in_z_imag       (s_z_imag),
        .in_start_count  (s_start_count),
        .out_final_count (m_final_count),
        .out_final_real  (m_final_real),
        .out_final_imag  (m_final_imag),
        .out_escaped     (m_escaped)
    );

endmodule

// ----- rtl/core/mei_mul.sv -----
// Sequential signed multiplier, one half-word partial product per cycle
module mei_mul (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [mei_pkg::DATA_BITS-1:0]  a,
    input  logic signed [mei_pkg::DATA_BITS-1:0]  b,
    output logic signed [mei_pkg::PROD_BITS-1:0]  prod,
    output logic                                  done
);

    localparam int H = mei_pkg::HALF_BITS;
    localparam int D = mei_pkg::DATA_BITS;
    localparam int P = mei_pkg::PROD_BITS;
    localparam int W = mei_pkg::PP_BITS;

    logic signed [D-1:0] a_reg, b_reg;
    logic [1:0]          step_reg;
    logic                busy_reg;
    logic signed [W-1:0] pp_reg;
    logic [1:0]          pp_step_reg;
    logic                pp_valid_reg;
    logic [P-1:0]        acc_reg;
    logic                done_reg;

    logic signed [H:0]   opa, opb;
    logic signed [W-1:0] pp_next;
    logic [P-1:0]        pp_ext, pp_shifted;

    // step bit 1 picks the half of a, bit 0 the half of b
    always_comb begin
        opa = step_reg[1] ? $signed({a_reg[D-1], a_reg[D-1:H]})
                          : $signed({1'b0, a_reg[H-1:0]});
        opb = step_reg[0] ? $signed({b_reg[D-1], b_reg[D-1:H]})
                          : $signed({1'b0, b_reg[H-1:0]});
        pp_next = opa * opb;
        pp_ext  = {{(P-W){pp_reg[W-1]}}, pp_reg};
        case (pp_step_reg)
            2'd0:    pp_shifted = pp_ext;
            2'd3:    pp_shifted = pp_ext << (2 * H);
            default: pp_shifted = pp_ext << H;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            step_reg     <= 2'd0;
            pp_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            pp_valid_reg <= busy_reg;
            done_reg     <= pp_valid_reg && (pp_step_reg == 2'd3);
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (pp_valid_reg) begin
            acc_reg <= acc_reg + pp_shifted;
        end
        if (busy_reg) begin
            pp_reg      <= pp_next;
            pp_step_reg <= step_reg;
        end
    end

    assign prod = $signed(acc_reg);
    assign done = done_reg;

endmodule

// ----- rtl/core/mei_datapath.sv -----
// Datapath: pixel registers, config registers, multiplier and write-back
module mei_datapath (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  mei_pkg::dp_cmd_t                           cmd,
    output mei_pkg::dp_sts_t                           sts,
    input  logic                                       cfg_valid,
    input  logic [mei_pkg::CFG_IDX_BITS-1:0]           cfg_index,
    input  logic [mei_pkg::CFG_DATA_BITS-1:0]          cfg_data,
    input  logic signed [mei_pkg::DATA_BITS-1:0]       in_c_real,
    input  logic signed [mei_pkg::DATA_BITS-1:0]       in_c_imag,
    input  logic signed [mei_pkg::DATA_BITS-1:0]       in_z_real,
    input  logic signed [mei_pkg::DATA_BITS-1:0]       in_z_imag,
    input  logic [mei_pkg::COUNT_BITS-1:0]             in_start_count,
    output logic [mei_pkg::COUNT_BITS-1:0]             out_final_count,
    output logic signed [mei_pkg::DATA_BITS-1:0]       out_final_real,
    output logic signed [mei_pkg::DATA_BITS-1:0]       out_final_imag,
    output logic                                       out_escaped
);

    localparam int D = mei_pkg::DATA_BITS;
    localparam int C = mei_pkg::COUNT_BITS;

    logic [C-1:0]                      max_count_reg;
    logic [mei_pkg::BAIL_BITS-1:0]     bailout_reg;
    logic [mei_pkg::POW_BITS-1:0]      power_reg;
    logic [mei_pkg::POW_BITS-1:0]      k_reg;

    logic signed [D-1:0] cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [D-1:0] re_reg, im_reg, t0_reg, t1_reg;
    logic [mei_pkg::SQ_BITS-1:0] sx_reg;
    logic [C-1:0]        count_reg;
    logic                esc_reg;

    logic [C-1:0]        o_count_reg;
    logic signed [D-1:0] o_real_reg, o_imag_reg;
    logic                o_esc_reg;

    logic signed [D-1:0]                 opa, opb;
    logic signed [mei_pkg::PROD_BITS-1:0] prod, prod_sh;
    logic                                mul_done;
    logic [mei_pkg::SQ_BITS-1:0]         sq;
    logic signed [D-1:0]                 fmul;
    logic [mei_pkg::MAG_BITS-1:0]        mag;
    logic                                mag_over;
    logic [mei_pkg::POW_BITS-1:0]        eff_power;

    function automatic logic signed [D-1:0] pick(mei_pkg::opd_sel_t sel,
                                                 logic signed [D-1:0] zr,
                                                 logic signed [D-1:0] zi,
                                                 logic signed [D-1:0] re,
                                                 logic signed [D-1:0] im);
        case (sel)
            mei_pkg::OPD_ZR: return zr;
            mei_pkg::OPD_ZI: return zi;
            mei_pkg::OPD_RE: return re;
            default:         return im;
        endcase
    endfunction

    assign opa = pick(cmd.a_sel, zr_reg, zi_reg, re_reg, im_reg);
    assign opb = pick(cmd.b_sel, zr_reg, zi_reg, re_reg, im_reg);

    mei_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (opa),
        .b       (opb),
        .prod    (prod),
        .done    (mul_done)
    );

    assign prod_sh   = prod >>> mei_pkg::FRAC_BITS;
    assign sq        = prod_sh[mei_pkg::SQ_BITS-1:0];
    assign fmul      = $signed(prod_sh[D-1:0]);
    assign mag       = mei_pkg::MAG_BITS'(sx_reg) + mei_pkg::MAG_BITS'(sq);
    assign mag_over  = mag > mei_pkg::MAG_BITS'(bailout_reg);
    assign eff_power = (power_reg < mei_pkg::POW_RESET) ? mei_pkg::POW_RESET : power_reg;

    assign sts.mul_done    = mul_done;
    assign sts.mag_over    = mag_over;
    assign sts.count_below = count_reg < max_count_reg;
    assign sts.pw_more     = k_reg < eff_power;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_count_reg <= mei_pkg::MAX_COUNT_RESET;
            bailout_reg   <= mei_pkg::BAIL_RESET;
            power_reg     <= mei_pkg::POW_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mei_pkg::CFG_MAX_COUNT: max_count_reg <= cfg_data[C-1:0];
                mei_pkg::CFG_BAILOUT:   bailout_reg   <= cfg_data[mei_pkg::BAIL_BITS-1:0];
                mei_pkg::CFG_POWER:     power_reg     <= cfg_data[mei_pkg::POW_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cr_reg    <= in_c_real;
            ci_reg    <= in_c_imag;
            zr_reg    <= in_z_real;
            zi_reg    <= in_z_imag;
            count_reg <= in_start_count;
            esc_reg   <= 1'b0;
        end
        if (cmd.pw_init) begin
            k_reg <= mei_pkg::POW_RESET;
        end else if (cmd.pw_step) begin
            k_reg <= k_reg + mei_pkg::POW_BITS'(1);
        end
        if (cmd.update) begin
            zr_reg    <= re_reg + cr_reg;
            zi_reg    <= im_reg + ci_reg;
            count_reg <= count_reg + C'(1);
        end
        if (mul_done) begin
            case (cmd.dst)
                mei_pkg::DST_SX: sx_reg <= sq;
                mei_pkg::DST_SY: begin
                    if (mag_over) begin
                        esc_reg <= 1'b1;
                    end else begin
                        re_reg <= $signed(sx_reg[D-1:0] - sq[D-1:0]);
                    end
                end
                mei_pkg::DST_CROSS: im_reg <= $signed({fmul[D-2:0], 1'b0});
                mei_pkg::DST_T0:    t0_reg <= fmul;
                mei_pkg::DST_T1:    t1_reg <= fmul;
                mei_pkg::DST_RE:    re_reg <= t0_reg - fmul;
                mei_pkg::DST_IM:    im_reg <= fmul + t1_reg;
                default: ;
            endcase
        end
        if (cmd.publish) begin
            o_count_reg <= count_reg;
            o_real_reg  <= zr_reg;
            o_imag_reg  <= zi_reg;
            o_esc_reg   <= esc_reg;
        end
    end

    assign out_final_count = o_count_reg;
    assign out_final_real  = o_real_reg;
    assign out_final_imag  = o_imag_reg;
    assign out_escaped     = o_esc_reg;

endmodule

// ----- rtl/core/mei_ctrl.sv -----
// Controller: per-pixel iteration sequencer and result handshake
`include "multibrot_escape_iteration_unit_macros.svh"

module mei_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output mei_pkg::dp_cmd_t  cmd,
    input  mei_pkg::dp_sts_t  sts
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_CHECK  = 12'b0000_0000_0010,
        ST_SQ_X   = 12'b0000_0000_0100,
        ST_SQ_Y   = 12'b0000_0000_1000,
        ST_CROSS  = 12'b0000_0001_0000,
        ST_POWER  = 12'b0000_0010_0000,
        ST_PW_RX  = 12'b0000_0100_0000,
        ST_PW_RY  = 12'b0000_1000_0000,
        ST_PW_IY  = 12'b0001_0000_0000,
        ST_PW_IX  = 12'b0010_0000_0000,
        ST_UPDATE = 12'b0100_0000_0000,
        ST_FINISH = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.a_sel     = mei_pkg::OPD_ZR;
        cmd.b_sel     = mei_pkg::OPD_ZR;
        cmd.dst       = mei_pkg::DST_NONE;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.count_below) begin
                    cmd.pw_init = 1'b1;
                    state_next  = ST_SQ_X;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SQ_X: begin
                cmd.dst = mei_pkg::DST_SX;
                if (sts.mul_done) state_next = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                cmd.a_sel = mei_pkg::OPD_ZI;
                cmd.b_sel = mei_pkg::OPD_ZI;
                cmd.dst   = mei_pkg::DST_SY;
                if (sts.mul_done) state_next = sts.mag_over ? ST_FINISH : ST_CROSS;
            end
            ST_CROSS: begin
                cmd.a_sel = mei_pkg::OPD_ZI;
                cmd.dst   = mei_pkg::DST_CROSS;
                if (sts.mul_done) state_next = ST_POWER;
            end
            ST_POWER: begin
                state_next = sts.pw_more ? ST_PW_RX : ST_UPDATE;
            end
            ST_PW_RX: begin
                cmd.a_sel = mei_pkg::OPD_RE;
                cmd.dst   = mei_pkg::DST_T0;
                if (sts.mul_done) state_next = ST_PW_RY;
            end
            ST_PW_RY: begin
                cmd.a_sel = mei_pkg::OPD_ZI;
                cmd.b_sel = mei_pkg::OPD_RE;
                cmd.dst   = mei_pkg::DST_T1;
                if (sts.mul_done) state_next = ST_PW_IY;
            end
            ST_PW_IY: begin
                cmd.a_sel = mei_pkg::OPD_IM;
                cmd.b_sel = mei_pkg::OPD_ZI;
                cmd.dst   = mei_pkg::DST_RE;
                if (sts.mul_done) state_next = ST_PW_IX;
            end
            ST_PW_IX: begin
                cmd.a_sel = mei_pkg::OPD_IM;
                cmd.dst   = mei_pkg::DST_IM;
                if (sts.mul_done) begin
                    cmd.pw_step = 1'b1;
                    state_next  = ST_POWER;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cmd.dst != mei_pkg::DST_NONE) begin
            cmd.mul_start = !issued_reg;
        end
        issued_next = sts.mul_done ? 1'b0 : (issued_reg || cmd.mul_start);
        if (cmd.publish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    `MEI_ASSERT_NXT(a_load_to_check, s_valid && s_ready, state_reg == ST_CHECK, "request not checked")
    `MEI_ASSERT_IMP(a_done_in_mul, sts.mul_done, issued_reg && (state_reg == ST_SQ_X || state_reg == ST_SQ_Y || state_reg == ST_CROSS || state_reg == ST_PW_RX || state_reg == ST_PW_RY || state_reg == ST_PW_IY || state_reg == ST_PW_IX), "stray multiply done")
    `MEI_ASSERT_NXT(a_publish_valid, cmd.publish, m_valid, "published result not valid")
    `MEI_ASSERT_NXT(a_finish_holds, state_reg == ST_FINISH && m_valid && !m_ready, state_reg == ST_FINISH, "result overwritten under stall")

endmodule

// ----- tb/tb_multibrot_escape_iteration_unit.sv -----
// Self-checking testbench for the multibrot escape iteration unit
module tb_multibrot_escape_iteration_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mei_pkg::*;

    localparam int WATCHDOG_LIMIT  = 100000;
    localparam int HOLD_OFF_CYCLES = 2000;
    localparam int DRAIN_CYCLES    = 64;
    localparam int MAX_REPORTS     = 40;
    localparam int FIXED_PHASES    = 6;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 70;
    localparam int DIR_ROWS        = 18;

    localparam logic [DATA_BITS-1:0] FX_ZERO     = '0;
    localparam logic [DATA_BITS-1:0] FX_LSB      = DATA_BITS'(1);
    localparam logic [DATA_BITS-1:0] FX_NEG_LSB  = -FX_LSB;
    localparam logic [DATA_BITS-1:0] FX_ONE      = DATA_BITS'(1) << FRAC_BITS;
    localparam logic [DATA_BITS-1:0] FX_NEG_ONE  = -FX_ONE;
    localparam logic [DATA_BITS-1:0] FX_TWO      = FX_ONE << 1;
    localparam logic [DATA_BITS-1:0] FX_NEG_TWO  = -FX_TWO;
    localparam logic [DATA_BITS-1:0] FX_QUARTER  = FX_ONE >> 2;
    localparam logic [DATA_BITS-1:0] FX_ONE_HALF = FX_ONE + (FX_ONE >> 1);
    localparam logic [DATA_BITS-1:0] FX_MAX      = {1'b0, {(DATA_BITS-1){1'b1}}};
    localparam logic [DATA_BITS-1:0] FX_MIN      = {1'b1, {(DATA_BITS-1){1'b0}}};
    localparam logic [COUNT_BITS-1:0] COUNT_ALL  = '1;
    localparam logic [BAIL_BITS-1:0]  BAIL_TOP   = '1;

    typedef struct packed {
        logic [DATA_BITS-1:0]  c_re;
        logic [DATA_BITS-1:0]  c_im;
        logic [DATA_BITS-1:0]  z_re;
        logic [DATA_BITS-1:0]  z_im;
        logic [COUNT_BITS-1:0] start;
    } pixel_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [DATA_BITS-1:0]  re;
        logic [DATA_BITS-1:0]  im;
        logic                  esc;
    } orbit_end_t;

    // typed rows leave z as given
    typedef struct packed {
        pixel_t                px;
        logic                  typed;
        logic [COUNT_BITS-1:0] x_count;
        logic                  x_esc;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{'{FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, COUNT_BITS'(0)},
          1'b1, COUNT_BITS'(256), 1'b0},
        '{'{FX_QUARTER, FX_ONE, FX_ONE, FX_NEG_ONE, COUNT_BITS'(256)},
          1'b1, COUNT_BITS'(256), 1'b0},
        '{'{FX_MAX, FX_MIN, FX_MAX, FX_MIN, COUNT_ALL},
          1'b1, COUNT_ALL, 1'b0},
        '{'{FX_ZERO, FX_ZERO, FX_MAX, FX_ZERO, COUNT_BITS'(5)},
          1'b1, COUNT_BITS'(5), 1'b1},
        '{'{FX_ZERO, FX_ZERO, FX_MIN, FX_MIN, COUNT_BITS'(0)},
          1'b1, COUNT_BITS'(0), 1'b1},
        '{'{FX_ZERO, FX_ZERO, FX_ZERO, FX_MAX, COUNT_BITS'(17)},
          1'b1, COUNT_BITS'(17), 1'b1},
        '{'{FX_ZERO, FX_ZERO, FX_TWO, FX_ZERO, COUNT_BITS'(0)},
          1'b0, COUNT_BITS'(0), 1'b0},
        '{'{FX_ZERO, FX_ZERO, FX_TWO + FX_LSB, FX_ZERO, COUNT_BITS'(0)},
          1'b1, COUNT_BITS'(0), 1'b1},
        '{'{FX_MIN, FX_MIN, FX_ZERO, FX_ZERO, COUNT_BITS'(0)},
          1'b0, COUNT_BITS'(0), 1'b0},
        '{'{FX_MAX, FX_MAX, FX_ZERO, FX_ZERO, COUNT_BITS'(0)},
          1'b0, COUNT_BITS'(0), 1'b0},
        '{'{FX_NEG_TWO, FX_ZERO, FX_ZERO, FX_ZERO, COUNT_BITS'(0)},
          1'b0, COUNT_BITS'(0), 1'b0},
        '{'{FX_NEG_ONE, FX_ZERO, FX_ZERO, FX_ZERO, COUNT_BITS'(0)},
          1'b0, COUNT_BITS'(0), 1'b0},
        '{'{FX_QUARTER, FX_ZERO, FX_ZERO, FX_ZERO, COUNT_BITS'(0)},
          1'b0, COUNT_BITS'(0), 1'b0},
        '{'{FX_ZERO, FX_ONE, FX_ZERO, FX_ZERO, COUNT_BITS'(0)},
          1'b0, COUNT_BITS'(0), 1'b0},
        '{'{FX_ZERO, FX_ZERO, FX_NEG_LSB, FX_LSB, COUNT_BITS'(0)},
          1'b0, COUNT_BITS'(0), 1'b0},
        '{'{FX_ONE, FX_NEG_ONE, FX_ZERO, FX_ZERO, COUNT_BITS'(255)},
          1'b0, COUNT_BITS'(0), 1'b0},
        '{'{FX_ZERO, FX_ZERO, FX_ONE, FX_ONE, COUNT_BITS'(257)},
          1'b1, COUNT_BITS'(257), 1'b0},
        '{'{FX_MAX, FX_ZERO, FX_ONE_HALF, FX_ZERO, COUNT_BITS'(0)},
          1'b0, COUNT_BITS'(0), 1'b0}
    };

    localparam logic [COUNT_BITS-1:0] PH_MAX_COUNT [FIXED_PHASES] = '{
        COUNT_BITS'(1), COUNT_ALL, COUNT_BITS'(20), COUNT_BITS'(12),
        COUNT_BITS'(6), COUNT_BITS'(300)
    };
    localparam logic [BAIL_BITS-1:0] PH_BAILOUT [FIXED_PHASES] = '{
        BAIL_BITS'(0), BAIL_TOP, BAIL_RESET, BAIL_BITS'(3) << FRAC_BITS,
        BAIL_BITS'(1) << FRAC_BITS, BAIL_BITS'(1) << (FRAC_BITS + 1)
    };
    localparam logic [POW_BITS-1:0] PH_POWER [FIXED_PHASES] = '{
        POW_BITS'(0), POW_BITS'(16), POW_BITS'(2), POW_BITS'(1), POW_BITS'(31),
        POW_BITS'(3)
    };

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [DATA_BITS-1:0]         s_c_real = '0;
    logic [DATA_BITS-1:0]         s_c_imag = '0;
    logic [DATA_BITS-1:0]         s_z_real = '0;
    logic [DATA_BITS-1:0]         s_z_imag = '0;
    logic [COUNT_BITS-1:0]        s_start_count = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [COUNT_BITS-1:0]        m_final_count;
    logic [DATA_BITS-1:0]         m_final_real;
    logic [DATA_BITS-1:0]         m_final_imag;
    logic                         m_escaped;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_BITS-1:0]      cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]     cfg_data = '0;

    logic [COUNT_BITS-1:0] cfg_max_count = MAX_COUNT_RESET;
    logic [BAIL_BITS-1:0]  cfg_bailout   = BAIL_RESET;
    logic [POW_BITS-1:0]   cfg_power     = POW_RESET;

    orbit_end_t  orbit_ends [$];
    int unsigned err_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned gap_pct = 20;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    multibrot_escape_iteration_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_c_real      (s_c_real),
        .s_c_imag      (s_c_imag),
        .s_z_real      (s_z_real),
        .s_z_imag      (s_z_imag),
        .s_start_count (s_start_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_final_count (m_final_count),
        .m_final_real  (m_final_real),
        .m_final_imag  (m_final_imag),
        .m_escaped     (m_escaped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [63:0] rnd_word();
        return {$urandom, $urandom};
    endfunction

    // full product, floored to the fixed-point scale, not wrapped
    function automatic logic signed [2*DATA_BITS-1:0] fx_prod(
        logic signed [DATA_BITS-1:0] a, logic signed [DATA_BITS-1:0] b);
        logic signed [2*DATA_BITS-1:0] wa, wb;
        wa = a;
        wb = b;
        return (wa * wb) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [DATA_BITS-1:0] fx_mul(
        logic signed [DATA_BITS-1:0] a, logic signed [DATA_BITS-1:0] b);
        logic signed [2*DATA_BITS-1:0] p;
        p = fx_prod(a, b);
        return p[DATA_BITS-1:0];
    endfunction

    function automatic orbit_end_t iterate_pixel(pixel_t px);
        logic signed [DATA_BITS-1:0]   zr, zi, re, im, t_rx, t_iy, t_ix, t_ry;
        logic signed [2*DATA_BITS-1:0] sq_r, sq_i;
        logic [2*DATA_BITS:0]          mag;
        logic [COUNT_BITS-1:0]         n;
        logic                          esc;
        int unsigned                   pe;
        orbit_end_t                    res;
        zr = px.z_re;
        zi = px.z_im;
        n = px.start;
        esc = 1'b0;
        pe = (cfg_power < POW_MIN) ? POW_MIN : cfg_power;
        while (!esc && n < cfg_max_count) begin
            sq_r = fx_prod(zr, zr);
            sq_i = fx_prod(zi, zi);
            mag = {1'b0, sq_r} + {1'b0, sq_i};
            if (mag > cfg_bailout) begin
                esc = 1'b1;
            end else begin
                re = sq_r[DATA_BITS-1:0] - sq_i[DATA_BITS-1:0];
                im = fx_mul(zi, zr) << 1;
                for (int k = POW_MIN; k < pe; k++) begin
                    t_ry = fx_mul(zi, re);
                    t_rx = fx_mul(re, zr);
                    t_ix = fx_mul(im, zr);
                    t_iy = fx_mul(im, zi);
                    re = t_rx - t_iy;
                    im = t_ix + t_ry;
                end
                zr = re + px.c_re;
                zi = im + px.c_im;
                n = n + 1'b1;
            end
        end
        res.count = n;
        res.re = zr;
        res.im = zi;
        res.esc = esc;
        return res;
    endfunction

    // iterations left per pixel are capped so that high powers stay cheap
    function automatic pixel_t make_pixel(bit tidy);
        pixel_t      px;
        int unsigned pe, cap, span;
        pe = (cfg_power < POW_MIN) ? POW_MIN : cfg_power;
        cap = 600 / (24 + 29 * (pe - POW_MIN));
        if (cap == 0)
            cap = 1;
        if (tidy) begin
            px.c_re = $signed(rnd_word()) >>> 2;
            px.c_im = $signed(rnd_word()) >>> 2;
            if ($urandom_range(0, 1)) begin
                px.z_re = '0;
                px.z_im = '0;
            end else begin
                px.z_re = $signed(rnd_word()) >>> 3;
                px.z_im = $signed(rnd_word()) >>> 3;
            end
            span = (cap < cfg_max_count) ? cap : cfg_max_count;
            if ($urandom_range(0, 7) == 0)
                px.start = cfg_max_count;
            else
                px.start = cfg_max_count - $urandom_range(1, span);
        end else begin
            px.c_re = rnd_word();
            px.c_im = rnd_word();
            px.z_re = rnd_word();
            px.z_im = rnd_word();
            px.start = $urandom;
            if (px.start < cfg_max_count && cfg_max_count - px.start > cap)
                px.start = cfg_max_count - $urandom_range(1, cap);
        end
        return px;
    endfunction

    task automatic offer_pixel(pixel_t px, bit typed, orbit_end_t want);
        int unsigned g;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            g = $urandom_range(1, 18);
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_c_real      <= px.c_re;
        s_c_imag      <= px.c_im;
        s_z_real      <= px.z_re;
        s_z_imag      <= px.z_im;
        s_start_count <= px.start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        orbit_ends.push_back(typed ? want : iterate_pixel(px));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (orbit_ends.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_MAX_COUNT: cfg_max_count = data[COUNT_BITS-1:0];
            CFG_BAILOUT:   cfg_bailout   = data[BAIL_BITS-1:0];
            CFG_POWER:     cfg_power     = data[POW_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic flag_field(string name, logic [DATA_BITS-1:0] want,
                              logic [DATA_BITS-1:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t %s mismatch: expected %h, got %h", $time, name, want, got);
    endtask

    always @(posedge aclk) begin : check_results
        orbit_end_t want;
        if (aresetn && m_valid && m_ready) begin
            if (orbit_ends.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t unexpected result: expected none, got count %0d",
                             $time, m_final_count);
            end else begin
                want = orbit_ends.pop_front();
                if (m_final_count !== want.count)
                    flag_field("final_count", want.count, m_final_count);
                if (m_final_real !== want.re)
                    flag_field("final_real", want.re, m_final_real);
                if (m_final_imag !== want.im)
                    flag_field("final_imag", want.im, m_final_imag);
                if (m_escaped !== want.esc)
                    flag_field("escaped", want.esc, m_escaped);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    initial begin
        pixel_t                px;
        orbit_end_t            want;
        logic [COUNT_BITS-1:0] mc;
        logic [BAIL_BITS-1:0]  bl;
        logic [POW_BITS-1:0]   pw;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows run at the reset settings
        for (int i = 0; i < DIR_ROWS; i++) begin
            want = '{DIRECTED[i].x_count, DIRECTED[i].px.z_re, DIRECTED[i].px.z_im,
                     DIRECTED[i].x_esc};
            offer_pixel(DIRECTED[i].px, DIRECTED[i].typed, want);
        end
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < FIXED_PHASES) begin
                mc = PH_MAX_COUNT[ph];
                bl = PH_BAILOUT[ph];
                pw = PH_POWER[ph];
            end else begin
                mc = $urandom_range(0, 1) ? $urandom_range(1, 64)
                                          : $urandom_range(1, 2**COUNT_BITS - 1);
                bl = $urandom_range(0, 1) ? rnd_word() >> 1
                                          : BAIL_BITS'($urandom_range(1, 16)) << (FRAC_BITS - 2);
                pw = $urandom_range(0, 2**POW_BITS - 1);
            end
            // junk above each register's width must be dropped
            write_reg(CFG_MAX_COUNT, (rnd_word() << COUNT_BITS) | mc);
            write_reg(CFG_BAILOUT, (rnd_word() << BAIL_BITS) | bl);
            write_reg(CFG_POWER, (rnd_word() << POW_BITS) | pw);
            cfg_valid <= 1'b0;
            gap_pct = 25 * $urandom_range(0, 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == PHASES - 1 && i >= PHASE_ITEMS / 2)
                    quiet = 1'b1;
                if (ph == 2 && i == 10)
                    hold_req = 1'b1;
                px = make_pixel($urandom_range(0, 3) != 0);
                offer_pixel(px, 1'b0, '0);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/mei_pkg.sv
rtl/core/mei_mul.sv
rtl/core/mei_datapath.sv
rtl/core/mei_ctrl.sv
rtl/core/multibrot_escape_iteration_unit.sv
tb/tb_multibrot_escape_iteration_unit.sv
